[design/bir_pkg.sv]
// ----------------------------------------------------------------------------
// bir_pkg
// shared types and constants of the bicubic image resampler
// ----------------------------------------------------------------------------
package bir_pkg;

    // configuration register indexes, byte address = 4 * index
    localparam logic [2:0] REG_SRC_W = 3'd0;
    localparam logic [2:0] REG_SRC_H = 3'd1;
    localparam logic [2:0] REG_DST_W = 3'd2;
    localparam logic [2:0] REG_DST_H = 3'd3;
    localparam logic [2:0] REG_CHN   = 3'd4;

    // divisor width: twice the largest destination size doubled again (<= 1024)
    localparam int DEN_W = 11;
    // kernel offset magnitude, Q.10, up to 3.0
    localparam int U_W   = 12;
    // signed Q0.10 fraction, -1024..1024
    localparam int DQ_W  = 12;
    // kernel weight, Q2.14 signed
    localparam int WGT_W = 16;
    // tap weight product, Q4.28 signed
    localparam int TAP_W = 32;
    // channel accumulator
    localparam int ACC_W = 44;

    typedef logic signed [WGT_W-1:0] t_weight;
    typedef logic signed [TAP_W-1:0] t_tap;
    typedef logic signed [ACC_W-1:0] t_acc;
    typedef logic [7:0]              t_pix;

endpackage

[design/bir_div.sv]
// ----------------------------------------------------------------------------
// bir_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module bir_div #(
    parameter int DVW = 21
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [DVW-1:0]              i_dividend,
    input  logic [bir_pkg::DEN_W-1:0]   i_divisor,
    output logic                        o_done,
    output logic [DVW-1:0]              o_quo,
    output logic [bir_pkg::DEN_W-1:0]   o_rem
);

    localparam int DSW = bir_pkg::DEN_W;
    localparam int CNW = $clog2(DVW + 1);

    logic [DVW-1:0] r_quo;
    logic [DSW-1:0] r_rem;
    logic [DSW-1:0] r_dvs;
    logic [CNW-1:0] r_cnt;
    logic           r_run;
    logic           r_done;
    logic [DSW:0]   n_trial;

    // trial subtraction of the shifted remainder
    assign n_trial = {r_rem, r_quo[DVW-1]} - {1'b0, r_dvs};

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= CNW'(DVW);
            end else if (r_run) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNW'(1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_run) begin
            if (!n_trial[DSW]) begin
                r_rem <= n_trial[DSW-1:0];
                r_quo <= {r_quo[DVW-2:0], 1'b1};
            end else begin
                r_rem <= {r_rem[DSW-2:0], r_quo[DVW-1]};
                r_quo <= {r_quo[DVW-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

endmodule

[design/bir_kernel.sv]
// ----------------------------------------------------------------------------
// bir_kernel
// keys cubic weight (a = -0.5) of a Q.10 offset magnitude, Q2.14 result
// ----------------------------------------------------------------------------
module bir_kernel (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [bir_pkg::U_W-1:0]   i_u,
    output logic                      o_done,
    output bir_pkg::t_weight          o_weight
);

    logic [2:0]                r_v;
    logic                      r_done;
    logic [bir_pkg::U_W-1:0]   r_u;
    logic [21:0]               r_u2;
    logic [33:0]               r_u3;
    logic [35:0]               r_u2k;
    bir_pkg::t_weight          r_w;
    logic signed [39:0]        n_num;
    logic [39:0]               n_mag;
    logic [22:0]               n_rnd;

    // stage valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v    <= '0;
            r_done <= 1'b0;
        end else begin
            r_v    <= {r_v[1:0], i_start};
            r_done <= r_v[2];
        end
    end

    // powers of the offset, one multiply per stage
    always_ff @(posedge i_clk) begin
        if (i_start) r_u <= i_u;
        r_u2  <= 22'(r_u * r_u);
        r_u3  <= 34'(r_u2 * r_u);
        r_u2k <= {2'b00, r_u2, 12'b0} + {4'b0000, r_u2, 10'b0};
    end

    // polynomial for the inner and outer segment
    always_comb begin
        if (!r_u[11] && !r_u[10]) begin
            n_num = $signed(40'(r_u3) * 40'sd3) - $signed(40'(r_u2k))
                    + 40'sh0080000000;
        end else begin
            n_num = $signed(40'(r_u2k)) - $signed(40'(r_u3))
                    - $signed({5'b0, r_u, 23'b0}) + 40'sh0100000000;
        end
        n_mag = n_num[39] ? 40'(-n_num) : 40'(n_num);
        n_rnd = 23'((n_mag + 40'h10000) >> 17);
    end

    // round half away from zero, zero beyond two
    always_ff @(posedge i_clk) begin
        if (r_v[2]) begin
            if (r_u[11]) begin
                r_w <= '0;
            end else if (n_num[39]) begin
                r_w <= bir_pkg::t_weight'(-$signed({1'b0, n_rnd[15:0]}));
            end else begin
                r_w <= bir_pkg::t_weight'(n_rnd[15:0]);
            end
        end
    end

    assign o_done   = r_done;
    assign o_weight = r_w;

endmodule

[design/bir_frame.sv]
// ----------------------------------------------------------------------------
// bir_frame
// source frame store, one write port and one registered read port
// ----------------------------------------------------------------------------
module bir_frame #(
    parameter int AW = 16,
    parameter int DW = 32
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [DW-1:0] i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [DW-1:0] o_rd_data
);

    logic [DW-1:0] r_mem [2**AW];
    logic [DW-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) r_mem[i_wr_addr] <= i_wr_data;
    end

    // read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

[design/bicubic_image_resampler.sv]
// ----------------------------------------------------------------------------
// bicubic_image_resampler
// catmull-rom bicubic resize from a stored source frame
// ----------------------------------------------------------------------------
// Command channel: an item transfers when start is high and busy is low.
// req_type 0 writes a source pixel into the frame store in that same edge;
// busy stays low, so writes may follow every cycle. req_type 1 requests a
// destination pixel; busy stays high until the cycle its result is shown.
// Result channel: o_done is high for exactly one cycle with out_x, out_y and
// the four channel values; the receiver must take it then.
// A request is served in turn by four divisions of DVW-bit dividends (21 bits
// at the default sizes) on one bit-serial divider that map both axes, one
// shared cubic unit that makes eight weights, and the single read port of
// the frame store, which gives sixteen taps, one per cycle. The next request
// can transfer at the edge that ends the result cycle and not before, so a
// new request is taken only once the last one is through.
// Configuration goes over the APB port, registers at 4*index, while idle.
// Reset restores register defaults and returns to idle; the frame store is
// not cleared, and pixels must be written before they are used.
// ----------------------------------------------------------------------------
module bicubic_image_resampler #(
    parameter int MAX_WIDTH    = 256,
    parameter int MAX_HEIGHT   = 256,
    parameter int MAX_CHANNELS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // command
    input  logic        start,
    output logic        busy,
    input  logic        i_req_type,
    input  logic [7:0]  i_pos_x,
    input  logic [7:0]  i_pos_y,
    input  logic [7:0]  i_in_ch0,
    input  logic [7:0]  i_in_ch1,
    input  logic [7:0]  i_in_ch2,
    input  logic [7:0]  i_in_ch3,
    // result
    output logic        o_done,
    output logic [7:0]  o_out_x,
    output logic [7:0]  o_out_y,
    output logic [7:0]  o_out_ch0,
    output logic [7:0]  o_out_ch1,
    output logic [7:0]  o_out_ch2,
    output logic [7:0]  o_out_ch3,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int XW   = $clog2(MAX_WIDTH);
    localparam int YW   = $clog2(MAX_HEIGHT);
    localparam int SXW  = $clog2(MAX_WIDTH + 1);
    localparam int SYW  = $clog2(MAX_HEIGHT + 1);
    localparam int SW   = (SXW > SYW) ? SXW : SYW;
    localparam int NUMW = 9 + SW;
    localparam int DVW  = (NUMW > 21) ? NUMW : 21;
    localparam int IW   = NUMW + 1;
    localparam int CXW  = IW + 1;
    localparam int AW   = XW + YW;
    localparam int DW   = 8 * MAX_CHANNELS;
    localparam int CHW  = 3;
    localparam logic [SXW-1:0] SRC_W_RST = SXW'((MAX_WIDTH < 256) ? MAX_WIDTH : 256);
    localparam logic [SYW-1:0] SRC_H_RST = SYW'((MAX_HEIGHT < 256) ? MAX_HEIGHT : 256);
    localparam logic [CHW-1:0] CHN_RST   = CHW'((MAX_CHANNELS < 3) ? MAX_CHANNELS : 3);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_KERN = 3'd2;
    localparam logic [2:0] S_TAP  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    // configuration registers
    logic [SXW-1:0] r_src_w;
    logic [SYW-1:0] r_src_h;
    logic [8:0]     r_dst_w;
    logic [8:0]     r_dst_h;
    logic [CHW-1:0] r_chn;
    logic           n_cfg_wr;

    assign pready   = 1'b1;
    assign n_cfg_wr = psel && penable && pwrite;

    // register writes, saturated to the legal range
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w <= SRC_W_RST;
            r_src_h <= SRC_H_RST;
            r_dst_w <= 9'd128;
            r_dst_h <= 9'd128;
            r_chn   <= CHN_RST;
        end else if (n_cfg_wr) begin
            case (paddr[4:2])
                bir_pkg::REG_SRC_W: begin
                    if (pwdata == 32'd0) r_src_w <= SXW'(1);
                    else if (pwdata > 32'(MAX_WIDTH)) r_src_w <= SXW'(MAX_WIDTH);
                    else r_src_w <= SXW'(pwdata);
                end
                bir_pkg::REG_SRC_H: begin
                    if (pwdata == 32'd0) r_src_h <= SYW'(1);
                    else if (pwdata > 32'(MAX_HEIGHT)) r_src_h <= SYW'(MAX_HEIGHT);
                    else r_src_h <= SYW'(pwdata);
                end
                bir_pkg::REG_DST_W: begin
                    if (pwdata == 32'd0) r_dst_w <= 9'd1;
                    else if (pwdata > 32'd256) r_dst_w <= 9'd256;
                    else r_dst_w <= pwdata[8:0];
                end
                bir_pkg::REG_DST_H: begin
                    if (pwdata == 32'd0) r_dst_h <= 9'd1;
                    else if (pwdata > 32'd256) r_dst_h <= 9'd256;
                    else r_dst_h <= pwdata[8:0];
                end
                bir_pkg::REG_CHN: begin
                    if (pwdata == 32'd0) r_chn <= CHW'(1);
                    else if (pwdata > 32'(MAX_CHANNELS)) r_chn <= CHW'(MAX_CHANNELS);
                    else r_chn <= pwdata[CHW-1:0];
                end
                default: ;
            endcase
        end
    end

    // register read back
    always_comb begin
        case (paddr[4:2])
            bir_pkg::REG_SRC_W: prdata = 32'(r_src_w);
            bir_pkg::REG_SRC_H: prdata = 32'(r_src_h);
            bir_pkg::REG_DST_W: prdata = 32'(r_dst_w);
            bir_pkg::REG_DST_H: prdata = 32'(r_dst_h);
            bir_pkg::REG_CHN:   prdata = 32'(r_chn);
            default:            prdata = 32'd0;
        endcase
    end

    // sequencer state
    logic [2:0]               r_state;
    logic [1:0]               r_dstep;
    logic                     r_dstart;
    logic [2:0]               r_kidx;
    logic                     r_kstart;
    logic [4:0]               r_tc;
    logic                     r_tv;
    logic [7:0]               r_px;
    logic [7:0]               r_py;
    logic                     r_fneg;
    logic [bir_pkg::DEN_W-1:0] r_frem;
    logic signed [IW-1:0]     r_ix;
    logic signed [IW-1:0]     r_iy;
    logic signed [bir_pkg::DQ_W-1:0] r_dqx;
    logic signed [bir_pkg::DQ_W-1:0] r_dqy;
    bir_pkg::t_weight         r_wx [4];
    bir_pkg::t_weight         r_wy [4];
    bir_pkg::t_tap            r_k;
    bir_pkg::t_acc            r_sum [MAX_CHANNELS];
    logic                     r_done;
    logic [7:0]               r_ox;
    logic [7:0]               r_oy;
    logic [7:0]               r_och [4];

    logic n_acc;
    logic n_wr;

    assign busy  = (r_state != S_IDLE);
    assign n_acc = start && !busy;
    assign n_wr  = n_acc && !i_req_type
                   && (16'(i_pos_x) < 16'(r_src_w)) && (16'(i_pos_y) < 16'(r_src_h));

    // axis mapping: num = (2p+1)*s - d, den = 2d
    logic [7:0]                n_p;
    logic [SW-1:0]             n_s;
    logic [8:0]                n_d;
    logic [NUMW-1:0]           n_prod;
    logic                      n_neg;
    logic [NUMW-1:0]           n_mag;
    logic [DVW-1:0]            n_dvd;
    logic [bir_pkg::DEN_W-1:0] n_dvs;
    logic                      w_ddone;
    logic [DVW-1:0]            w_quo;
    logic [bir_pkg::DEN_W-1:0] w_rem;

    always_comb begin
        n_p    = r_dstep[1] ? r_py : r_px;
        n_s    = r_dstep[1] ? SW'(r_src_h) : SW'(r_src_w);
        n_d    = r_dstep[1] ? r_dst_h : r_dst_w;
        n_prod = NUMW'({n_p, 1'b1} * n_s);
        n_neg  = n_prod < NUMW'(n_d);
        n_mag  = n_neg ? (NUMW'(n_d) - n_prod) : (n_prod - NUMW'(n_d));
        if (!r_dstep[0]) begin
            // whole part
            n_dvd = DVW'(n_mag);
            n_dvs = bir_pkg::DEN_W'({n_d, 1'b0});
        end else begin
            // fraction rounded to Q0.10: (|f|*2048 + den) / (2*den)
            n_dvd = DVW'({r_frem[9:0], 11'b0}) + DVW'({n_d, 1'b0});
            n_dvs = {n_d, 2'b00};
        end
    end

    bir_div #(
        .DVW (DVW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_dstart),
        .i_dividend (n_dvd),
        .i_divisor  (n_dvs),
        .o_done     (w_ddone),
        .o_quo      (w_quo),
        .o_rem      (w_rem)
    );

    // kernel offset t = (n-1)*1024 - d
    logic signed [13:0]              n_t;
    logic signed [bir_pkg::DQ_W-1:0] n_dq;
    logic [bir_pkg::U_W-1:0]         n_u;
    logic                            w_kdone;
    bir_pkg::t_weight                w_weight;

    always_comb begin
        n_dq = r_kidx[2] ? r_dqy : r_dqx;
        n_t  = $signed({2'b00, r_kidx[1:0], 10'b0}) - 14'sd1024
               - $signed({{2{n_dq[bir_pkg::DQ_W-1]}}, n_dq});
        n_u  = n_t[13] ? bir_pkg::U_W'(-n_t) : bir_pkg::U_W'(n_t);
    end

    bir_kernel u_kernel (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_kstart),
        .i_u      (n_u),
        .o_done   (w_kdone),
        .o_weight (w_weight)
    );

    // neighbour address, clamped to the frame
    logic signed [CXW-1:0] n_cx;
    logic signed [CXW-1:0] n_cy;
    logic [XW-1:0]         n_rx;
    logic [YW-1:0]         n_ry;

    always_comb begin
        n_cx = CXW'(r_ix) + $signed(CXW'(r_tc[1:0])) - CXW'(1);
        n_cy = CXW'(r_iy) + $signed(CXW'(r_tc[3:2])) - CXW'(1);
        if (n_cx < 0) n_rx = '0;
        else if (n_cx > $signed(CXW'(r_src_w) - CXW'(1))) n_rx = XW'(r_src_w - 1'b1);
        else n_rx = XW'(n_cx);
        if (n_cy < 0) n_ry = '0;
        else if (n_cy > $signed(CXW'(r_src_h) - CXW'(1))) n_ry = YW'(r_src_h - 1'b1);
        else n_ry = YW'(n_cy);
    end

    // frame store
    logic [DW-1:0] n_wdata;
    logic [DW-1:0] w_rdata;
    logic          n_rd;
    logic [31:0]   n_word;

    assign n_word  = {i_in_ch3, i_in_ch2, i_in_ch1, i_in_ch0};
    assign n_wdata = n_word[DW-1:0];
    assign n_rd    = (r_state == S_TAP) && !r_tc[4];

    bir_frame #(
        .AW (AW),
        .DW (DW)
    ) u_frame (
        .i_clk     (i_clk),
        .i_wr_en   (n_wr),
        .i_wr_addr ({YW'(i_pos_y), XW'(i_pos_x)}),
        .i_wr_data (n_wdata),
        .i_rd_en   (n_rd),
        .i_rd_addr ({n_ry, n_rx}),
        .o_rd_data (w_rdata)
    );

    // sequencer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_dstep  <= '0;
            r_dstart <= 1'b0;
            r_kidx   <= '0;
            r_kstart <= 1'b0;
            r_tc     <= '0;
            r_tv     <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_dstart <= 1'b0;
            r_kstart <= 1'b0;
            r_done   <= 1'b0;
            r_tv     <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (n_acc && i_req_type) begin
                        r_state  <= S_DIV;
                        r_dstep  <= '0;
                        r_dstart <= 1'b1;
                    end
                end
                S_DIV: begin
                    if (w_ddone) begin
                        if (r_dstep == 2'd3) begin
                            r_state  <= S_KERN;
                            r_kidx   <= '0;
                            r_kstart <= 1'b1;
                        end else begin
                            r_dstep  <= r_dstep + 1'b1;
                            r_dstart <= 1'b1;
                        end
                    end
                end
                S_KERN: begin
                    if (w_kdone) begin
                        if (r_kidx == 3'd7) begin
                            r_state <= S_TAP;
                            r_tc    <= '0;
                        end else begin
                            r_kidx   <= r_kidx + 1'b1;
                            r_kstart <= 1'b1;
                        end
                    end
                end
                S_TAP: begin
                    if (!r_tc[4]) begin
                        r_tc <= r_tc + 1'b1;
                        r_tv <= 1'b1;
                    end else begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // request position, axis results from the divider and weights from the kernel
    always_ff @(posedge i_clk) begin
        if (n_acc && i_req_type) begin
            r_px <= i_pos_x;
            r_py <= i_pos_y;
        end
        if (r_state == S_DIV && w_ddone) begin
            if (!r_dstep[0]) begin
                r_fneg <= n_neg;
                r_frem <= w_rem;
                if (r_dstep[1]) r_iy <= n_neg ? -$signed(IW'(w_quo)) : $signed(IW'(w_quo));
                else            r_ix <= n_neg ? -$signed(IW'(w_quo)) : $signed(IW'(w_quo));
            end else begin
                if (r_dstep[1]) begin
                    r_dqy <= r_fneg ? -$signed(bir_pkg::DQ_W'(w_quo))
                                    : $signed(bir_pkg::DQ_W'(w_quo));
                end else begin
                    r_dqx <= r_fneg ? -$signed(bir_pkg::DQ_W'(w_quo))
                                    : $signed(bir_pkg::DQ_W'(w_quo));
                end
            end
        end
        if (r_state == S_KERN && w_kdone) begin
            if (r_kidx[2]) r_wy[r_kidx[1:0]] <= w_weight;
            else           r_wx[r_kidx[1:0]] <= w_weight;
        end
    end

    // tap weight, registered alongside the pixel read so the two line up
    always_ff @(posedge i_clk) begin
        if (n_rd) r_k <= bir_pkg::t_tap'(r_wx[r_tc[1:0]] * r_wy[r_tc[3:2]]);
    end

    // per channel accumulation, final rounding and clamping to 0..255; unused channels give zero
    for (genvar c = 0; c < 4; c++) begin : g_ch
        if (c < MAX_CHANNELS) begin : g_used
            bir_pkg::t_acc n_rnd;
            assign n_rnd = (r_sum[c] + bir_pkg::t_acc'(2**27)) >>> 28;

            always_ff @(posedge i_clk) begin
                if (n_acc && i_req_type) begin
                    r_sum[c] <= '0;
                end else if (r_tv) begin
                    r_sum[c] <= r_sum[c] + bir_pkg::t_acc'(r_k
                                * $signed({1'b0, w_rdata[8*c +: 8]}));
                end
            end

            always_ff @(posedge i_clk) begin
                if (r_state == S_FIN) begin
                    if (CHW'(c) >= r_chn || r_sum[c] < 0) r_och[c] <= 8'd0;
                    else if (n_rnd > bir_pkg::t_acc'(255)) r_och[c] <= 8'd255;
                    else r_och[c] <= n_rnd[7:0];
                end
            end
        end else begin : g_none
            always_ff @(posedge i_clk) begin
                if (r_state == S_FIN) r_och[c] <= 8'd0;
            end
        end
    end

    // result coordinates
    always_ff @(posedge i_clk) begin
        if (r_state == S_FIN) begin
            r_ox <= r_px;
            r_oy <= r_py;
        end
    end

    assign o_done    = r_done;
    assign o_out_x   = r_ox;
    assign o_out_y   = r_oy;
    assign o_out_ch0 = r_och[0];
    assign o_out_ch1 = r_och[1];
    assign o_out_ch2 = r_och[2];
    assign o_out_ch3 = r_och[3];

endmodule
